[design/bso_pkg.sv]
// Shared types, codes and default sizes of the binary square opening block.
package bso_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 7;

  // Configuration port shape.
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_RADIUS  = 2'd2;

  // Configuration reset values.
  localparam logic [8:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd256;
  localparam logic [2:0] OPEN_RADIUS_RST  = 3'd1;

  // Result status codes.
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Sequencer states of the pass engine.
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SWEEP,
    ENG_DRAIN
  } eng_state_t;

  // The four separable passes, in run order.
  typedef enum logic [1:0] {
    PASS_ERODE_H  = 2'd0,
    PASS_ERODE_V  = 2'd1,
    PASS_DILATE_H = 2'd2,
    PASS_DILATE_V = 2'd3
  } pass_t;

  // Memory strobes driven by the pass engine.
  typedef struct packed {
    logic src_re;
    logic scr_re;
    logic opn_re;
    logic scr_we;
    logic opn_we;
    logic wdata;
  } eng_ctl_t;

endpackage

[design/bso_bitram.sv]
// Single-bit synchronous RAM with one write port and one registered read port.
module bso_bitram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/bso_pass_engine.sv]
// Sequencer that sweeps the frame through the four erosion and dilation passes.
module bso_pass_engine import bso_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int LWX        = $clog2(MAX_WIDTH + 1),
  parameter int LHX        = $clog2(MAX_HEIGHT + 1),
  parameter int RW         = $clog2(MAX_RADIUS + 1),
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [LWX-1:0] frame_w,
  input  logic [LHX-1:0] frame_h,
  input  logic [RW-1:0]  radius,
  output logic           busy,
  output eng_ctl_t       ctl,
  output logic [AW-1:0]  src_raddr,
  output logic [AW-1:0]  win_raddr,
  output logic [AW-1:0]  waddr,
  input  logic           src_rdata,
  input  logic           scr_rdata,
  input  logic           opn_rdata
);

  localparam int MAX_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LENW    = $clog2(MAX_LEN + 1);
  localparam int QW      = $clog2(MAX_LEN + MAX_RADIUS + 1);
  localparam int LNW     = $clog2(MAX_LEN);
  localparam int WIN     = 2 * MAX_RADIUS + 1;

  eng_state_t       state_r, state_nxt;
  pass_t            pass_r, pass_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [LNW-1:0]   line_r, line_nxt;

  logic             s1_act_r, s1_rd_r, s1_wr_r, s1_first_r;
  logic [AW-1:0]    s1_addr_r;
  logic [WIN-1:0]   win_r;

  logic             sweeping, vertical, erode, outside;
  logic [LENW-1:0]  len, lines;
  logic [QW-1:0]    q_last, p_pos;
  logic [LNW-1:0]   line_last;
  logic             rd_ok, wr_ok;
  logic             new_bit, and_acc, or_acc, result;
  logic [WIN-1:0]   win_base, win_nxt;

  // Entry of a pixel given its line and its position along the line.
  function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] pos,
                                            input logic [LNW-1:0] line,
                                            input logic vert);
    logic [31:0] xv;
    logic [31:0] yv;
    xv = vert ? 32'(line) : 32'(pos);
    yv = vert ? 32'(pos) : 32'(line);
    return AW'(yv * MAX_WIDTH + xv);
  endfunction

  // Pass geometry.
  assign sweeping  = (state_r == ENG_SWEEP);
  assign vertical  = (pass_r == PASS_ERODE_V) || (pass_r == PASS_DILATE_V);
  assign erode     = (pass_r == PASS_ERODE_H) || (pass_r == PASS_ERODE_V);
  assign outside   = erode;
  assign len       = vertical ? LENW'(frame_h) : LENW'(frame_w);
  assign lines     = vertical ? LENW'(frame_w) : LENW'(frame_h);
  assign q_last    = QW'(len) + QW'(radius) - QW'(1);
  assign line_last = LNW'(lines - LENW'(1));
  assign rd_ok     = sweeping && (QW'(len) > q_r);
  assign wr_ok     = sweeping && (q_r >= QW'(radius));
  assign p_pos     = q_r - QW'(radius);

  // Read side: the window memory runs r positions ahead of the written pixel.
  assign win_raddr  = addr_of(q_r, line_r, vertical);
  assign src_raddr  = (pass_r == PASS_ERODE_H) ? addr_of(q_r, line_r, vertical)
                                               : addr_of(p_pos, line_r, vertical);
  assign ctl.src_re = ((pass_r == PASS_ERODE_H) && rd_ok) ||
                      ((pass_r == PASS_DILATE_V) && wr_ok);
  assign ctl.scr_re = rd_ok && vertical;
  assign ctl.opn_re = rd_ok && (pass_r == PASS_DILATE_H);

  // Window shift and reduction over the 2r+1 newest bits.
  always_comb begin
    case (pass_r)
      PASS_ERODE_H:  new_bit = src_rdata;
      PASS_DILATE_H: new_bit = opn_rdata;
      default:       new_bit = scr_rdata;
    endcase
    if (!s1_rd_r) begin
      new_bit = outside;
    end
    win_base = s1_first_r ? {WIN{outside}} : win_r;
    win_nxt  = {win_base[WIN-2:0], new_bit};
    and_acc  = 1'b1;
    or_acc   = 1'b0;
    for (int i = 0; i < WIN; i++) begin
      if (i <= 2 * int'(radius)) begin
        and_acc = and_acc & win_nxt[i];
        or_acc  = or_acc | win_nxt[i];
      end
    end
    result = erode ? and_acc : or_acc;
    if (pass_r == PASS_DILATE_V) begin
      result = result & src_rdata;
    end
  end

  // Write side.
  assign waddr      = s1_addr_r;
  assign ctl.wdata  = result;
  assign ctl.scr_we = s1_wr_r && ((pass_r == PASS_ERODE_H) || (pass_r == PASS_DILATE_H));
  assign ctl.opn_we = s1_wr_r && ((pass_r == PASS_ERODE_V) || (pass_r == PASS_DILATE_V));
  assign busy       = (state_r != ENG_IDLE);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    q_nxt     = q_r;
    line_nxt  = line_r;
    case (state_r)
      ENG_IDLE: begin
        if (start) begin
          state_nxt = ENG_SWEEP;
          pass_nxt  = PASS_ERODE_H;
          q_nxt     = '0;
          line_nxt  = '0;
        end
      end
      ENG_SWEEP: begin
        if (q_r == q_last) begin
          q_nxt = '0;
          if (line_r == line_last) begin
            line_nxt  = '0;
            state_nxt = ENG_DRAIN;
          end else begin
            line_nxt = line_r + LNW'(1);
          end
        end else begin
          q_nxt = q_r + QW'(1);
        end
      end
      ENG_DRAIN: begin
        case (pass_r)
          PASS_ERODE_H: begin
            pass_nxt  = PASS_ERODE_V;
            state_nxt = ENG_SWEEP;
          end
          PASS_ERODE_V: begin
            pass_nxt  = PASS_DILATE_H;
            state_nxt = ENG_SWEEP;
          end
          PASS_DILATE_H: begin
            pass_nxt  = PASS_DILATE_V;
            state_nxt = ENG_SWEEP;
          end
          default: begin
            state_nxt = ENG_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  // Sequencer and second stage control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ENG_IDLE;
      pass_r   <= PASS_ERODE_H;
      q_r      <= '0;
      line_r   <= '0;
      s1_act_r <= 1'b0;
      s1_rd_r  <= 1'b0;
      s1_wr_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pass_r   <= pass_nxt;
      q_r      <= q_nxt;
      line_r   <= line_nxt;
      s1_act_r <= sweeping;
      s1_rd_r  <= rd_ok;
      s1_wr_r  <= wr_ok;
    end
  end

  // Second stage payload and window.
  always_ff @(posedge clk) begin
    s1_first_r <= (q_r == '0);
    s1_addr_r  <= addr_of(p_pos, line_r, vertical);
    if (s1_act_r) begin
      win_r <= win_nxt;
    end
  end

endmodule

[design/binary_square_opening.sv]
// Top level of the binary square opening block: requests, stores and clearing.
//
// Requests enter on the in_ channel (valid/stall) and each one yields exactly
// one result on the out_ channel, in order. A pixel write or read is taken
// into the request stage on acceptance and its result then leaves through
// the output register; back-to-back writes and reads stream at one request
// per cycle while the receiver keeps out_stall low.
// A run request answers at once but then holds in_stall high while the pass
// engine sweeps the frame four times through the memories, one pixel a cycle.
// The window read of each pass runs R positions ahead of the pixel written.
// After reset a clearing pass writes zero to every entry of the source and
// opened stores while in_stall stays high; configuration writes are taken
// during that pass as ever.
// When the receiver stalls, the finished result waits in the output register
// and one more request may be accepted into the stage behind it; after that
// in_stall rises until the output register is taken.
// Configuration is written on cfg_wr_en with cfg_index and cfg_wr_data; the
// user must do so only while no request is in flight; the block never checks.
module binary_square_opening import bso_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [7:0]            in_x_pos,
  input  logic [7:0]            in_y_pos,
  input  logic                  in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_opened_value,
  output logic                  out_status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LWX   = $clog2(MAX_WIDTH + 1);
  localparam int LHX   = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);

  logic [8:0]     frame_width_r, frame_height_r;
  logic [2:0]     open_radius_r;
  logic [LWX-1:0] eff_w;
  logic [LHX-1:0] eff_h;
  logic [RW-1:0]  eff_r;

  logic           clr_active_r;
  logic [AW-1:0]  clr_cnt_r;

  logic           p_valid_r, p_read_r, p_oob_r;
  logic           out_valid_r, out_opened_value_r, out_status_r;

  req_t           req;
  logic           in_acc, p_moves, oob, req_src_we, req_opn_re, run_start;
  logic [AW-1:0]  req_addr;

  logic           eng_busy;
  eng_ctl_t       eng_ctl;
  logic [AW-1:0]  eng_src_raddr, eng_win_raddr, eng_waddr;
  logic           src_rdata, scr_rdata, opn_rdata;

  logic           src_we, src_wdata, opn_we, opn_wdata, opn_re;
  logic [AW-1:0]  src_waddr, opn_waddr, opn_raddr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      open_radius_r  <= OPEN_RADIUS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wr_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data;
        CFG_OPEN_RADIUS:  open_radius_r  <= cfg_wr_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Saturated frame size and radius.
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = LWX'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      eff_w = LWX'(MAX_WIDTH);
    end else begin
      eff_w = LWX'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = LHX'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      eff_h = LHX'(MAX_HEIGHT);
    end else begin
      eff_h = LHX'(frame_height_r);
    end
    if (32'(open_radius_r) > MAX_RADIUS) begin
      eff_r = RW'(MAX_RADIUS);
    end else begin
      eff_r = RW'(open_radius_r);
    end
  end

  // Request decode and handshake.
  assign req        = req_t'(in_req_type);
  assign p_moves    = !out_valid_r || !out_stall;
  assign in_stall   = clr_active_r || eng_busy || (p_valid_r && !p_moves);
  assign in_acc     = in_valid && !in_stall;
  assign oob        = ((req == REQ_WRITE) || (req == REQ_READ)) &&
                      ((32'(in_x_pos) >= 32'(eff_w)) || (32'(in_y_pos) >= 32'(eff_h)));
  assign req_addr   = AW'(32'(in_y_pos) * MAX_WIDTH + 32'(in_x_pos));
  assign req_src_we = in_acc && (req == REQ_WRITE) && !oob;
  assign req_opn_re = in_acc && (req == REQ_READ) && !oob;
  assign run_start  = in_acc && (req == REQ_RUN);

  // Clearing pass over the source and opened stores after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Memory port selection between clearing, requests and the pass engine.
  assign src_we    = clr_active_r || req_src_we;
  assign src_waddr = clr_active_r ? clr_cnt_r : req_addr;
  assign src_wdata = clr_active_r ? 1'b0 : in_pixel_value;
  assign opn_we    = clr_active_r || eng_ctl.opn_we;
  assign opn_waddr = clr_active_r ? clr_cnt_r : eng_waddr;
  assign opn_wdata = clr_active_r ? 1'b0 : eng_ctl.wdata;
  assign opn_re    = eng_busy ? eng_ctl.opn_re : req_opn_re;
  assign opn_raddr = eng_busy ? eng_win_raddr : req_addr;

  bso_bitram #(.DEPTH(DEPTH), .AW(AW)) u_source_store (
    .clk     (clk),
    .we      (src_we),
    .waddr   (src_waddr),
    .wdata   (src_wdata),
    .re      (eng_ctl.src_re),
    .raddr   (eng_src_raddr),
    .rd_data (src_rdata)
  );

  bso_bitram #(.DEPTH(DEPTH), .AW(AW)) u_scratch_store (
    .clk     (clk),
    .we      (eng_ctl.scr_we),
    .waddr   (eng_waddr),
    .wdata   (eng_ctl.wdata),
    .re      (eng_ctl.scr_re),
    .raddr   (eng_win_raddr),
    .rd_data (scr_rdata)
  );

  bso_bitram #(.DEPTH(DEPTH), .AW(AW)) u_opened_store (
    .clk     (clk),
    .we      (opn_we),
    .waddr   (opn_waddr),
    .wdata   (opn_wdata),
    .re      (opn_re),
    .raddr   (opn_raddr),
    .rd_data (opn_rdata)
  );

  bso_pass_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .LWX        (LWX),
    .LHX        (LHX),
    .RW         (RW),
    .AW         (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (run_start),
    .frame_w   (eff_w),
    .frame_h   (eff_h),
    .radius    (eff_r),
    .busy      (eng_busy),
    .ctl       (eng_ctl),
    .src_raddr (eng_src_raddr),
    .win_raddr (eng_win_raddr),
    .waddr     (eng_waddr),
    .src_rdata (src_rdata),
    .scr_rdata (scr_rdata),
    .opn_rdata (opn_rdata)
  );

  // Request stage that waits for the opened store read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_acc) begin
      p_valid_r <= 1'b1;
    end else if (p_moves) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_read_r <= (req == REQ_READ) && !oob;
      p_oob_r  <= oob;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_valid_r && p_moves) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid_r && p_moves) begin
      out_opened_value_r <= p_read_r & opn_rdata;
      out_status_r       <= p_oob_r ? STATUS_OUTSIDE : STATUS_DONE;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_opened_value = out_opened_value_r;
  assign out_status       = out_status_r;

`ifndef ASSERT_OFF
  // No request may slip in while the stores are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_acc)
    else $error("request accepted during clearing pass");

  // A run keeps the engine busy on the following cycle.
  a_run_starts_engine: assert property (@(posedge clk) disable iff (!rst_n)
    run_start |=> eng_busy)
    else $error("run request did not start the pass engine");

  // The engine never sweeps while the clearing pass owns the stores.
  a_engine_not_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !eng_busy)
    else $error("pass engine active during clearing pass");

  // A waiting result is not lost while the output register is stalled.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && out_valid_r && out_stall) |=> p_valid_r)
    else $error("request stage dropped a result under stall");

  // Request reads of the opened store never collide with an engine sweep.
  a_no_read_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    eng_busy |-> !req_opn_re)
    else $error("pixel read accepted during a run");
`endif

endmodule
